// ----- hdl/rcm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcm_pkg: shared types and constants of the RC channel mapper
// Field widths, register map, reset values, state codes and the helpers
// that turn a channel sample into divider operands and clamp the quotient.
// ----------------------------------------------------------------------------
package rcm_pkg;

	// field widths
	localparam int PULSE_W = 15;
	localparam int LEVEL_W = 10;
	localparam int HOLD_W  = 16;
	localparam int TIME_W  = 32;
	localparam int VALUE_W = 8;
	localparam int STATE_W = 2;

	// divider operand widths: |x - lo| * 200 fits 23 bits, |hi - lo| fits 15
	localparam int DIV_NUM_W = 23;
	localparam int DIV_DEN_W = PULSE_W;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 5;

	typedef enum logic [2:0] {
		REG_ARM_HIGH    = 3'd0,
		REG_ARM_LOW     = 3'd1,
		REG_ARM_HOLD    = 3'd2,
		REG_SWITCH_THR  = 3'd3,
		REG_A_IN_START  = 3'd4,
		REG_A_IN_END    = 3'd5,
		REG_B_IN_START  = 3'd6,
		REG_B_IN_END    = 3'd7
	} reg_idx_t;

	// register reset values
	localparam logic [LEVEL_W-1:0] RST_ARM_HIGH   = 10'd300;
	localparam logic [LEVEL_W-1:0] RST_ARM_LOW    = 10'd200;
	localparam logic [HOLD_W-1:0]  RST_ARM_HOLD   = 16'd500;
	localparam logic [PULSE_W-1:0] RST_SWITCH_THR = 15'd1800;
	localparam logic [PULSE_W-1:0] RST_A_IN_START = 15'd2015;
	localparam logic [PULSE_W-1:0] RST_A_IN_END   = 15'd1075;
	localparam logic [PULSE_W-1:0] RST_B_IN_START = 15'd1469;
	localparam logic [PULSE_W-1:0] RST_B_IN_END   = 15'd1575;

	// output codes and limits
	localparam logic [STATE_W-1:0] SWITCH_OFF  = 2'd0;
	localparam logic [STATE_W-1:0] SWITCH_LOW  = 2'd1;
	localparam logic [STATE_W-1:0] SWITCH_HIGH = 2'd2;

	localparam logic signed [VALUE_W-1:0] OUT_MIN   = -8'sd100;
	localparam logic signed [VALUE_W-1:0] OUT_MAX   = 8'sd100;
	localparam logic signed [VALUE_W-1:0] DEADBAND  = 8'sd5;
	localparam logic [VALUE_W-1:0]        MAP_SPAN  = 8'd200;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_PREP = 3'b010,
		S_RUN  = 3'b100
	} seq_state_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// operands of one channel map
	typedef struct packed {
		logic [DIV_NUM_W-1:0] num_mag;
		logic [DIV_DEN_W-1:0] den_mag;
		logic                 neg;
	} map_op_t;

	// split (x - lo) * 200 / (hi - lo) into magnitudes and a sign;
	// a zero span reads as a negative result, which maps to the low end
	function automatic map_op_t map_operands(
		input logic [PULSE_W-1:0] x,
		input logic [PULSE_W-1:0] lo,
		input logic [PULSE_W-1:0] hi
	);
		logic [PULSE_W:0]     dn;
		logic [PULSE_W:0]     dd;
		logic [PULSE_W:0]     an;
		logic [PULSE_W:0]     ad;
		logic [PULSE_W-1:0]   mag;
		map_op_t              op;
		dn  = {1'b0, x} - {1'b0, lo};
		dd  = {1'b0, hi} - {1'b0, lo};
		an  = dn[PULSE_W] ? (~dn + 1'b1) : dn;
		ad  = dd[PULSE_W] ? (~dd + 1'b1) : dd;
		mag = an[PULSE_W-1:0];
		// times 200 as 128 + 64 + 8
		op.num_mag = {1'b0, mag, 7'b0} + {2'b0, mag, 6'b0} + {5'b0, mag, 3'b0};
		op.den_mag = ad[PULSE_W-1:0];
		op.neg     = (dn[PULSE_W] ^ dd[PULSE_W]) | (ad == '0);
		return op;
	endfunction

	// clamp a quotient magnitude to -100..100 after the offset
	function automatic logic signed [VALUE_W-1:0] map_finish(
		input logic [DIV_NUM_W-1:0] q_mag,
		input logic                 neg
	);
		logic [VALUE_W-1:0]       qs;
		logic signed [VALUE_W:0]  v;
		qs = (q_mag > DIV_NUM_W'(MAP_SPAN)) ? MAP_SPAN : q_mag[VALUE_W-1:0];
		v  = $signed({1'b0, qs}) - $signed({OUT_MAX[VALUE_W-1], OUT_MAX});
		return neg ? OUT_MIN : v[VALUE_W-1:0];
	endfunction

endpackage

// ----- hdl/rcm_if.sv -----
// ----------------------------------------------------------------------------
// rcm_if: frame and result channels of the RC channel mapper
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface rcm_in_if
	import rcm_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] switch_pulse_us;
	logic [PULSE_W-1:0] axis_a_pulse_us;
	logic [PULSE_W-1:0] axis_b_pulse_us;
	logic [LEVEL_W-1:0] arm_level;
	logic [TIME_W-1:0]  now_ms;

	modport source (
		output valid, switch_pulse_us, axis_a_pulse_us, axis_b_pulse_us, arm_level,
			now_ms,
		input  ready
	);
	modport sink (
		input  valid, switch_pulse_us, axis_a_pulse_us, axis_b_pulse_us, arm_level,
			now_ms,
		output ready
	);
endinterface

interface rcm_out_if
	import rcm_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic [STATE_W-1:0]         switch_state;
	logic signed [VALUE_W-1:0]  axis_a_value;
	logic signed [VALUE_W-1:0]  axis_b_value;
	logic                       armed;

	modport source (
		output valid, switch_state, axis_a_value, axis_b_value, armed,
		input  ready
	);
	modport sink (
		input  valid, switch_state, axis_a_value, axis_b_value, armed,
		output ready
	);
endinterface

// ----- hdl/rcm_div.sv -----
// ----------------------------------------------------------------------------
// rcm_div: bit-serial restoring divider
// Shifts the dividend out one bit per cycle and the quotient in, one
// trial subtract per cycle.
// ----------------------------------------------------------------------------
module rcm_div
	import rcm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num_mag,
	input  logic [DIV_DEN_W-1:0] den_mag,
	output logic [DIV_NUM_W-1:0] q_mag,
	output div_stat_t            stat
);
	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic [DIV_NUM_W-1:0] acc_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DEN_W+1:0] trial;
	logic                 q_bit;

	// trial subtract of the divisor from the shifted partial remainder
	assign trial = {1'b0, rem_q, acc_q[DIV_NUM_W-1]} - {2'b0, den_q};
	assign q_bit = ~trial[DIV_DEN_W+1];

	// control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(DIV_NUM_W);
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: shift dividend out, quotient in, keep the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= num_mag;
			rem_q <= '0;
			den_q <= den_mag;
		end else if (busy_q) begin
			acc_q <= {acc_q[DIV_NUM_W-2:0], q_bit};
			if (q_bit) begin
				rem_q <= trial[DIV_DEN_W-1:0];
			end else begin
				rem_q <= {rem_q[DIV_DEN_W-2:0], acc_q[DIV_NUM_W-1]};
			end
		end
	end

	assign q_mag     = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/rc_channel_mapper_with_arming.sv -----
// ----------------------------------------------------------------------------
// rc_channel_mapper_with_arming: RC pulse-width mapper with an arming gate
// Turns three pulse widths into a switch code and two clamped axis values,
// gated by a latched, timed arming level.
// ----------------------------------------------------------------------------
// Usage:
//   frame_in carries one frame per transaction: three pulse widths, the
//   arming level and the millisecond time. result_out returns exactly one
//   result per frame, in order. Both are valid/ready channels.
//   The APB port holds the eight thresholds and map ends; write it only
//   while no frame is in flight. pready is always high.
// Frame sequence:
//   After its transaction a frame passes the arming update and operand
//   setup in S_PREP, the two bit-serial dividers in S_RUN (one quotient
//   bit per cycle, both axes in parallel) and the load of the output
//   register, which waits while an untaken result is held there. The input
//   turns ready again in the cycle after the load, so a new frame is taken
//   only once the last one has been loaded.
// Reset:
//   arst_n clears the channels, loads the register reset values and leaves
//   the block disarmed with no latch held.
// Stall:
//   A result waits in the output register; one further frame is worked
//   through and then held until result_out takes the waiting one.
// ----------------------------------------------------------------------------
module rc_channel_mapper_with_arming
	import rcm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	rcm_in_if.sink                frame_in,
	rcm_out_if.source             result_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	// configuration registers
	logic [LEVEL_W-1:0] arm_high_q;
	logic [LEVEL_W-1:0] arm_low_q;
	logic [HOLD_W-1:0]  arm_hold_q;
	logic [PULSE_W-1:0] switch_thr_q;
	logic [PULSE_W-1:0] a_start_q;
	logic [PULSE_W-1:0] a_end_q;
	logic [PULSE_W-1:0] b_start_q;
	logic [PULSE_W-1:0] b_end_q;
	reg_idx_t           reg_idx;
	logic               cfg_write;

	// captured frame
	logic [PULSE_W-1:0] sw_q;
	logic [PULSE_W-1:0] ax_q;
	logic [PULSE_W-1:0] bx_q;
	logic [LEVEL_W-1:0] lvl_q;
	logic [TIME_W-1:0]  now_q;

	// arming state
	logic               latched_q;
	logic               disarmed_q;
	logic [TIME_W-1:0]  latch_time_q;
	logic               latched_d;
	logic               disarmed_d;
	logic [TIME_W-1:0]  latch_time_d;
	logic [TIME_W-1:0]  elapsed;

	// sequencing and mapping
	seq_state_t           state_q;
	map_op_t              op_a;
	map_op_t              op_b;
	logic                 neg_a_q;
	logic                 neg_b_q;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] q_a;
	logic [DIV_NUM_W-1:0] q_b;
	div_stat_t            stat_a;
	div_stat_t            stat_b;
	logic                 out_free;
	logic                 finish;
	logic signed [VALUE_W-1:0] val_a;
	logic signed [VALUE_W-1:0] val_b;

	// result register
	logic                      out_valid_q;
	logic [STATE_W-1:0]        out_state_q;
	logic signed [VALUE_W-1:0] out_a_q;
	logic signed [VALUE_W-1:0] out_b_q;
	logic                      out_armed_q;

	// ---------------- configuration port ----------------
	assign reg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_write = psel & penable & pwrite;
	assign pready    = 1'b1;

	// write a register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_high_q   <= RST_ARM_HIGH;
			arm_low_q    <= RST_ARM_LOW;
			arm_hold_q   <= RST_ARM_HOLD;
			switch_thr_q <= RST_SWITCH_THR;
			a_start_q    <= RST_A_IN_START;
			a_end_q      <= RST_A_IN_END;
			b_start_q    <= RST_B_IN_START;
			b_end_q      <= RST_B_IN_END;
		end else if (cfg_write) begin
			case (reg_idx)
				REG_ARM_HIGH:   arm_high_q   <= pwdata[LEVEL_W-1:0];
				REG_ARM_LOW:    arm_low_q    <= pwdata[LEVEL_W-1:0];
				REG_ARM_HOLD:   arm_hold_q   <= pwdata[HOLD_W-1:0];
				REG_SWITCH_THR: switch_thr_q <= pwdata[PULSE_W-1:0];
				REG_A_IN_START: a_start_q    <= pwdata[PULSE_W-1:0];
				REG_A_IN_END:   a_end_q      <= pwdata[PULSE_W-1:0];
				REG_B_IN_START: b_start_q    <= pwdata[PULSE_W-1:0];
				REG_B_IN_END:   b_end_q      <= pwdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// read back a register
	always_comb begin
		case (reg_idx)
			REG_ARM_HIGH:   prdata = APB_DATA_W'(arm_high_q);
			REG_ARM_LOW:    prdata = APB_DATA_W'(arm_low_q);
			REG_ARM_HOLD:   prdata = APB_DATA_W'(arm_hold_q);
			REG_SWITCH_THR: prdata = APB_DATA_W'(switch_thr_q);
			REG_A_IN_START: prdata = APB_DATA_W'(a_start_q);
			REG_A_IN_END:   prdata = APB_DATA_W'(a_end_q);
			REG_B_IN_START: prdata = APB_DATA_W'(b_start_q);
			REG_B_IN_END:   prdata = APB_DATA_W'(b_end_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- frame capture ----------------
	assign frame_in.ready = (state_q == S_IDLE);

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			sw_q  <= frame_in.switch_pulse_us;
			ax_q  <= frame_in.axis_a_pulse_us;
			bx_q  <= frame_in.axis_b_pulse_us;
			lvl_q <= frame_in.arm_level;
			now_q <= frame_in.now_ms;
		end
	end

	// ---------------- arming update ----------------
	// latch first, then disarm, then the hold test
	always_comb begin
		latched_d    = latched_q;
		disarmed_d   = disarmed_q;
		latch_time_d = latch_time_q;
		if (lvl_q > arm_high_q && !latched_q) begin
			latch_time_d = now_q;
			latched_d    = 1'b1;
		end
		if (lvl_q < arm_low_q) begin
			disarmed_d = 1'b1;
			latched_d  = 1'b0;
		end
		elapsed = now_q - latch_time_d;
		if (latched_d && elapsed > TIME_W'(arm_hold_q)) begin
			disarmed_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q    <= 1'b0;
			disarmed_q   <= 1'b1;
			latch_time_q <= '0;
		end else if (state_q == S_PREP) begin
			latched_q    <= latched_d;
			disarmed_q   <= disarmed_d;
			latch_time_q <= latch_time_d;
		end
	end

	// ---------------- channel maps ----------------
	assign op_a      = map_operands(ax_q, a_start_q, a_end_q);
	assign op_b      = map_operands(bx_q, b_start_q, b_end_q);
	assign div_start = (state_q == S_PREP);

	// hold the quotient signs while the dividers run
	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_a_q <= op_a.neg;
			neg_b_q <= op_b.neg;
		end
	end

	rcm_div u_div_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (op_a.num_mag),
		.den_mag (op_a.den_mag),
		.q_mag   (q_a),
		.stat    (stat_a)
	);

	rcm_div u_div_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num_mag (op_b.num_mag),
		.den_mag (op_b.den_mag),
		.q_mag   (q_b),
		.stat    (stat_b)
	);

	// offset, clamp and apply the axis-A deadband
	always_comb begin
		val_a = map_finish(q_a, neg_a_q);
		val_b = map_finish(q_b, neg_b_q);
		if (val_a < DEADBAND && val_a > -DEADBAND) begin
			val_a = '0;
		end
	end

	// ---------------- sequencer ----------------
	assign out_free = !out_valid_q || result_out.ready;
	assign finish   = (state_q == S_RUN) && stat_a.done && stat_b.done
		&& !stat_a.busy && !stat_b.busy && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (frame_in.valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: state_q <= S_RUN;
				S_RUN: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// load the result, zeroed while disarmed
	always_ff @(posedge clk) begin
		if (finish) begin
			out_armed_q <= !disarmed_q;
			if (disarmed_q) begin
				out_state_q <= SWITCH_OFF;
				out_a_q     <= '0;
				out_b_q     <= '0;
			end else begin
				out_state_q <= (sw_q > switch_thr_q) ? SWITCH_HIGH : SWITCH_LOW;
				out_a_q     <= val_a;
				out_b_q     <= val_b;
			end
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.switch_state = out_state_q;
	assign result_out.axis_a_value = out_a_q;
	assign result_out.axis_b_value = out_b_q;
	assign result_out.armed        = out_armed_q;

endmodule
